/* rtl/clvb_pkg.sv */
package clvb_pkg;

   localparam int DEF_ASSOC          = 4;
   localparam int DEF_VICTIM_ENTRIES = 4;
   localparam int BLOCK_BYTES        = 1024;
   localparam int HEAP_BYTES         = 65536;
   localparam int ADDR_BITS          = 32;

   localparam int NUM_LINES  = HEAP_BYTES / BLOCK_BYTES;
   localparam int OFS_W      = $clog2(BLOCK_BYTES);
   localparam int BLK_W      = ADDR_BITS - OFS_W;
   localparam int ST_W       = 2;
   localparam int ENT_W      = BLK_W + ST_W;
   localparam int LINE_W     = 7;
   localparam int FROM_W     = 6;
   localparam int SIZE_W     = 11;
   localparam int OUTCOME_W  = 2;
   localparam int CSR_W      = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 88;
   localparam int RES_W      = 85;

   typedef logic [ST_W-1:0]      status_type;
   typedef logic [OUTCOME_W-1:0] outcome_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam status_type ST_INVALID = 2'd0;
   localparam status_type ST_VALID   = 2'd1;
   localparam status_type ST_DIRTY   = 2'd2;

   localparam outcome_type OUT_NONE   = 2'd0;
   localparam outcome_type OUT_HIT    = 2'd1;
   localparam outcome_type OUT_VICTIM = 2'd2;
   localparam outcome_type OUT_MISS   = 2'd3;

   localparam csr_idx_type CSR_HEAP_BASE  = 1'b0;
   localparam csr_idx_type CSR_HEAP_LIMIT = 1'b1;

   typedef enum logic {
      S_IDLE,
      S_LOOK
   } state_type;

endpackage

/* rtl/clvb_ram.sv */
module clvb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cache_lookup_with_victim_buffer_top.sv */
// Heap cache lookup: translates one load/store per beat against a set-associative
// cache (per-set FIFO replacement) backed by a small FIFO victim buffer, and reports
// hit, victim hit or miss together with the writeback, move and fetch a miss needs.
// Addresses outside [heap_base, heap_limit) return an all-zero result. An item's set
// row (tags, status, FIFO pointer) is read from the set memory, then compared and
// written back with the result once the output register is free; the next item is
// accepted once the row is written. Results sit in an output register, so
// an item can be taken while the previous result still waits. The set memory needs
// no clearing pass after reset: a per-set valid flag makes unwritten rows read empty.
module cache_lookup_with_victim_buffer_top #(
   parameter int ASSOC          = clvb_pkg::DEF_ASSOC,
   parameter int VICTIM_ENTRIES = clvb_pkg::DEF_VICTIM_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   // config write port
   input  logic                              csr_we,
   input  logic [clvb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [clvb_pkg::CSR_W-1:0]        csr_wdata,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // addr[31:0], data_size[42:32], zero pad
   input  logic [clvb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op[0]
   input  logic [0:0]                        req_tuser,
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // line_index[6:0], byte_offset[16:7], writeback_valid[17], writeback_line[24:18],
   // writeback_block[46:25], move_valid[47], move_from_line[53:48],
   // move_to_line[60:54], fetch_valid[61], fetch_block[83:62], overflow[84], zero pad
   output logic [clvb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // outcome[1:0]
   output logic [clvb_pkg::OUTCOME_W-1:0]    rsp_tuser
);

   localparam int NUM_LINES = clvb_pkg::NUM_LINES;
   localparam int SET_COUNT = NUM_LINES / ASSOC;
   localparam int SET_W     = $clog2(SET_COUNT);
   localparam int WAY_W     = (ASSOC > 1) ? $clog2(ASSOC) : 1;
   localparam int VIDX_W    = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
   localparam int ENT_W     = clvb_pkg::ENT_W;
   localparam int ST_W      = clvb_pkg::ST_W;
   localparam int BLK_W     = clvb_pkg::BLK_W;
   localparam int OFS_W     = clvb_pkg::OFS_W;
   localparam int LINE_W    = clvb_pkg::LINE_W;
   localparam int ROW_W     = ASSOC * ENT_W + WAY_W;

   // configuration
   logic [clvb_pkg::CSR_W-1:0] base_ff, limit_ff;

   // control
   clvb_pkg::state_type state_ff, state_in;
   logic                row_valid_ff [SET_COUNT];
   logic [VIDX_W-1:0]   vptr_ff, vptr_in;

   // captured item
   logic                         store_ff, heap_ff, rowv_ff;
   logic [BLK_W-1:0]             blk_ff;
   logic [OFS_W-1:0]             boff_ff;
   logic [clvb_pkg::SIZE_W-1:0]  size_ff;

   // victim buffer
   logic [BLK_W-1:0]             vic_blk_ff [VICTIM_ENTRIES];
   logic [BLK_W-1:0]             vic_blk_in [VICTIM_ENTRIES];
   clvb_pkg::status_type         vic_st_ff  [VICTIM_ENTRIES];
   clvb_pkg::status_type         vic_st_in  [VICTIM_ENTRIES];

   // output register
   logic                          rsp_valid_ff;
   logic [clvb_pkg::RES_W-1:0]    rsp_data_ff;
   clvb_pkg::outcome_type         rsp_outcome_ff;

   logic [31:0]                   req_addr;
   logic [clvb_pkg::SIZE_W-1:0]   req_size;
   logic [SET_W-1:0]              req_set, set_ff;
   logic                          req_heap, accept, out_free, commit;

   logic [ROW_W-1:0]              rd_row, row, row_in;
   logic [BLK_W-1:0]              wblk [ASSOC];
   clvb_pkg::status_type          wst  [ASSOC];
   logic [WAY_W-1:0]              fp;

   logic                          way_hit, vic_hit;
   logic [WAY_W-1:0]              hit_way;
   logic [VIDX_W-1:0]             vic_idx;

   clvb_pkg::outcome_type         res_outcome;
   logic [LINE_W-1:0]             res_line, res_wb_line, res_to_line, miss_line;
   logic [OFS_W-1:0]              res_boff;
   logic                          res_wbv, res_mv, res_fv, res_ovf;
   logic [BLK_W-1:0]              res_wb_blk, res_fetch_blk;
   logic [clvb_pkg::FROM_W-1:0]   res_from;
   logic [OFS_W+1:0]              end_sum;

   assign req_addr = req_tdata[31:0];
   assign req_size = req_tdata[42:32];
   assign req_set  = req_addr[OFS_W +: SET_W];
   assign req_heap = (req_addr >= base_ff) && (req_addr < limit_ff);

   assign req_tready = (state_ff == clvb_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == clvb_pkg::S_LOOK) && out_free;
   assign set_ff     = blk_ff[SET_W-1:0];

   // row layout: {fifo pointer, way[ASSOC-1] .. way[0]}, way = {block, status}
   clvb_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SET_COUNT)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (commit && heap_ff),
      .wr_addr (set_ff),
      .wr_data (row_in),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (rd_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clvb_pkg::S_IDLE;
         base_ff  <= '0;
         limit_ff <= '0;
         vptr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SET_COUNT; s++) begin
            row_valid_ff[s] <= 1'b0;
         end
         for (int v = 0; v < VICTIM_ENTRIES; v++) begin
            vic_st_ff[v] <= clvb_pkg::ST_INVALID;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == clvb_pkg::CSR_HEAP_BASE) begin
            base_ff <= csr_wdata;
         end
         if (csr_we && csr_index == clvb_pkg::CSR_HEAP_LIMIT) begin
            limit_ff <= csr_wdata;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            vptr_ff      <= vptr_in;
            vic_st_ff    <= vic_st_in;
            if (heap_ff) begin
               row_valid_ff[set_ff] <= 1'b1;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff <= req_tuser[0];
         heap_ff  <= req_heap;
         blk_ff   <= req_addr[OFS_W +: BLK_W];
         boff_ff  <= req_addr[OFS_W-1:0];
         size_ff  <= req_size;
         rowv_ff  <= row_valid_ff[req_set];
      end
      if (commit) begin
         vic_blk_ff     <= vic_blk_in;
         rsp_outcome_ff <= res_outcome;
         rsp_data_ff    <= {res_ovf, res_fetch_blk, res_fv, res_to_line, res_from, res_mv,
                            res_wb_blk, res_wb_line, res_wbv, res_boff, res_line};
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         clvb_pkg::S_IDLE: begin
            if (accept) begin
               state_in = clvb_pkg::S_LOOK;
            end
         end
         clvb_pkg::S_LOOK: begin
            if (out_free) begin
               state_in = clvb_pkg::S_IDLE;
            end
         end
         default: state_in = clvb_pkg::S_IDLE;
      endcase
   end

   // unpack the set row; a never-written row reads as empty
   always_comb begin
      row = rowv_ff ? rd_row : '0;
      fp  = (ASSOC > 1) ? row[ROW_W-1 -: WAY_W] : '0;
      for (int w = 0; w < ASSOC; w++) begin
         wblk[w] = row[w*ENT_W + ST_W +: BLK_W];
         wst[w]  = row[w*ENT_W +: ST_W];
      end
   end

   // lowest matching way, then lowest matching victim entry
   always_comb begin
      way_hit = 1'b0;
      hit_way = '0;
      for (int w = ASSOC - 1; w >= 0; w--) begin
         if (wst[w] != clvb_pkg::ST_INVALID && wblk[w] == blk_ff) begin
            way_hit = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
      vic_hit = 1'b0;
      vic_idx = '0;
      for (int v = VICTIM_ENTRIES - 1; v >= 0; v--) begin
         if (vic_st_ff[v] != clvb_pkg::ST_INVALID && vic_blk_ff[v] == blk_ff) begin
            vic_hit = 1'b1;
            vic_idx = VIDX_W'(v);
         end
      end
   end

   always_comb begin
      row_in        = row;
      vic_blk_in    = vic_blk_ff;
      vic_st_in     = vic_st_ff;
      vptr_in       = vptr_ff;
      res_outcome   = clvb_pkg::OUT_NONE;
      res_line      = '0;
      res_boff      = '0;
      res_wbv       = 1'b0;
      res_wb_line   = '0;
      res_wb_blk    = '0;
      res_mv        = 1'b0;
      res_from      = '0;
      res_to_line   = '0;
      res_fv        = 1'b0;
      res_fetch_blk = '0;
      res_ovf       = 1'b0;
      end_sum       = {2'b00, boff_ff} + {1'b0, size_ff};
      miss_line     = LINE_W'(set_ff) * LINE_W'(ASSOC) + LINE_W'(fp);
      if (heap_ff) begin
         res_boff = boff_ff;
         res_ovf  = (end_sum > (OFS_W+2)'(clvb_pkg::BLOCK_BYTES));
         if (way_hit) begin
            res_outcome = clvb_pkg::OUT_HIT;
            res_line    = LINE_W'(set_ff) * LINE_W'(ASSOC) + LINE_W'(hit_way);
            if (store_ff) begin
               row_in[ENT_W*int'(hit_way) +: ST_W] = clvb_pkg::ST_DIRTY;
            end
         end else if (vic_hit) begin
            res_outcome = clvb_pkg::OUT_VICTIM;
            res_line    = LINE_W'(NUM_LINES) + LINE_W'(vic_idx);
            if (store_ff) begin
               vic_st_in[vic_idx] = clvb_pkg::ST_DIRTY;
            end
         end else begin
            res_outcome = clvb_pkg::OUT_MISS;
            res_line    = miss_line;
            if (vic_st_ff[vptr_ff] == clvb_pkg::ST_DIRTY) begin
               res_wbv     = 1'b1;
               res_wb_line = LINE_W'(NUM_LINES) + LINE_W'(vptr_ff);
               res_wb_blk  = vic_blk_ff[vptr_ff];
            end
            // replaced way goes to the victim buffer only if it holds a line
            if (wst[fp] != clvb_pkg::ST_INVALID) begin
               vic_blk_in[vptr_ff] = wblk[fp];
               vic_st_in[vptr_ff]  = wst[fp];
               res_mv      = 1'b1;
               res_from    = miss_line[clvb_pkg::FROM_W-1:0];
               res_to_line = LINE_W'(NUM_LINES) + LINE_W'(vptr_ff);
               vptr_in     = (vptr_ff == VIDX_W'(VICTIM_ENTRIES - 1)) ? '0 : vptr_ff + 1'b1;
            end
            row_in[ENT_W*int'(fp) +: ENT_W] =
               {blk_ff, store_ff ? clvb_pkg::ST_DIRTY : clvb_pkg::ST_VALID};
            row_in[ROW_W-1 -: WAY_W] = (ASSOC > 1) ? fp + 1'b1 : '0;
            res_fv        = 1'b1;
            res_fetch_blk = blk_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_outcome_ff;
   assign rsp_tdata  = {{(clvb_pkg::RSP_DATA_W - clvb_pkg::RES_W){1'b0}}, rsp_data_ff};

`ifndef SYNTHESIS
   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == clvb_pkg::S_LOOK))
      else $error("accepted beat did not start a lookup");

   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_tvalid)
      else $error("finished lookup produced no response beat");

   a_no_accept_in_look: assert property (@(posedge clock) disable iff (reset)
      (state_ff == clvb_pkg::S_LOOK) |-> !req_tready)
      else $error("request taken while a lookup is in flight");

   a_row_marked: assert property (@(posedge clock) disable iff (reset)
      (commit && heap_ff) |=> row_valid_ff[$past(set_ff)])
      else $error("written set row not flagged valid");

   a_vptr_range: assert property (@(posedge clock) disable iff (reset)
      int'(vptr_ff) < VICTIM_ENTRIES)
      else $error("victim pointer out of range");
`endif

endmodule
